[design/level_tracker_hysteresis_slew_core_macros.svh]
// Assertion macros shared by the level tracker checker.
`ifndef LEVEL_TRACKER_HYSTERESIS_SLEW_CORE_MACROS_SVH
`define LEVEL_TRACKER_HYSTERESIS_SLEW_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define LTHS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that also holds while reset is high.
`define LTHS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

[design/lths_pkg.sv]
// Package with types, codes and constants of the level tracker.
`timescale 1ns / 1ps
`default_nettype none

package lths_pkg;

   // Default width of the millisecond timestamps.
   localparam int TIME_BITS_DEFAULT = 48;

   // Field widths of the transfers.
   localparam int LEVEL_IN_BITS = 16;
   localparam int LEVEL_BITS    = 15;
   localparam int STATUS_BITS   = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 22;

   // Opcodes of an input transfer.
   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFERENCE_LEVEL = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRACKING_RANGE  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HYSTERESIS_BAND = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TIME_MS    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHON_RATE       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYPASS_MODE     = 3'd5;

   // Configuration reset values.
   localparam logic signed [14:0] REFERENCE_LEVEL_RESET = 15'sd10880;
   localparam logic [12:0] TRACKING_RANGE_RESET  = 13'd1920;
   localparam logic [9:0]  HYSTERESIS_BAND_RESET = 10'd128;
   localparam logic [21:0] HOLD_TIME_MS_RESET    = 22'd30000;
   localparam logic [15:0] PHON_RATE_RESET       = 16'd242;

   // Timing and slew constants.
   localparam int STALE_MS      = 2000;
   localparam int ELAPSED_BITS  = 27;
   localparam int ELAPSED_MAX   = 1 << 26;
   localparam int PRODUCT_BITS  = 16 + ELAPSED_BITS;
   localparam int STEP_MAX      = 32767;
   localparam int STEP_BITS     = 15;
   localparam longint STEP_SAT_PRODUCT = 64'd32768000;
   localparam signed [15:0] LEVEL_MIN = -16'sd16384;

   // Reciprocal of 1000 scaled by 2**35, exact for dividends below 2**25.
   localparam int QUOT_IN_BITS = 25;
   localparam int RECIP_BITS   = 26;
   localparam int RECIP_SHIFT  = 35;
   localparam logic [RECIP_BITS-1:0] RECIP_1000 = 26'd34359739;

   // Status codes of a result transfer.
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_WAITING   = 3'd0,
      STATUS_BYPASSED  = 3'd1,
      STATUS_RELEASING = 3'd2,
      STATUS_STALE     = 3'd3,
      STATUS_TRACKING  = 3'd4
   } status_type;

   // Control word that travels with an item down the pipeline.
   typedef struct packed {
      logic                  meas_update;
      logic                  first;
      logic                  tick_active;
      logic                  pull;
      logic                  elapsed_nz;
      status_type            status;
      logic signed [LEVEL_BITS-1:0] level;
   } stage_ctl_type;

endpackage

`default_nettype wire

[design/level_tracker_hysteresis_slew_core.sv]
// Loudness level tracker with hysteresis deadband and slew-rate limit.
//
// Usage: the req_ channel carries one item per transfer, either a level
// measurement (opcode 0) or a time tick (opcode 1), each with a millisecond
// timestamp. Every accepted item gives exactly one result on the rsp_
// channel: status, target level, tracked level and a curve refresh flag.
// Registers are written on the csr_ channel, which is always ready; write
// them only while no item is in flight.
// A new item is taken in every cycle while req_stall is low. The pipeline
// registers are the input register, time and status decode, rate times
// elapsed multiply, and the division by 1000 done as a reciprocal multiply,
// then the result register, ahead of which the target and tracked levels
// are updated. When the receiver stalls, the result register holds; stages
// behind it keep filling until the pipeline is full, and only then is
// req_stall raised.
// Reset (synchronous, active high) empties the pipeline, returns the
// registers to their defaults and sets both levels to 10880.
`timescale 1ns / 1ps
`default_nettype none

module level_tracker_hysteresis_slew_core #(
   parameter int TIME_BITS = lths_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Input item channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_opcode,
   input  wire logic signed [lths_pkg::LEVEL_IN_BITS-1:0] req_level,
   input  wire logic                                   req_level_valid,
   input  wire logic [TIME_BITS-1:0]                   req_timestamp_ms,
   // Result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [lths_pkg::STATUS_BITS-1:0]            rsp_status,
   output logic signed [lths_pkg::LEVEL_BITS-1:0]      rsp_target_level,
   output logic signed [lths_pkg::LEVEL_BITS-1:0]      rsp_tracked_level,
   output logic                                        rsp_curve_refresh,
   // Configuration write channel
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [lths_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [lths_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   import lths_pkg::*;

   localparam logic [TIME_BITS-1:0] ELAPSED_CAP = TIME_BITS'(ELAPSED_MAX);
   localparam logic [TIME_BITS-1:0] STALE_LIMIT = TIME_BITS'(STALE_MS);

   // Configuration registers
   logic signed [14:0] reference_level_ff;
   logic [12:0]        tracking_range_ff;
   logic [9:0]         hysteresis_band_ff;
   logic [21:0]        hold_time_ms_ff;
   logic [15:0]        phon_rate_ff;
   logic               bypass_mode_ff;

   // Pipeline valids and enables
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic en0, en1, en2, en3, en_out;

   // Input register
   logic                            s0_opcode_ff;
   logic signed [LEVEL_IN_BITS-1:0] s0_level_ff;
   logic                            s0_level_valid_ff;
   logic [TIME_BITS-1:0]            s0_ts_ff;

   // Time and status state
   status_type           mode_status_ff, mode_status_in;
   logic                 seen_ff, seen_in;
   logic [TIME_BITS-1:0] measure_time_ff, measure_time_in;
   logic [TIME_BITS-1:0] advance_time_ff, advance_time_in;

   // Stage data
   stage_ctl_type            s1_ctl_in, s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic [ELAPSED_BITS-1:0]  s1_elapsed_in, s1_elapsed_ff;
   logic [PRODUCT_BITS-1:0]  s2_product_ff;
   logic [STEP_BITS-1:0]     s3_step_in, s3_step_ff;

   // Level state and result registers
   logic signed [15:0] target_ff, target_in;
   logic signed [15:0] tracked_ff, tracked_in;
   logic [STATUS_BITS-1:0]       rsp_status_ff;
   logic signed [LEVEL_BITS-1:0] rsp_target_ff, rsp_tracked_ff;
   logic                         rsp_refresh_ff, refresh_in;

   // Handshake: a stage takes an item when it is empty or its item moves on.
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en3       = !s3_valid_ff || en_out;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign en0       = !s0_valid_ff || en1;
   assign req_stall = !en0;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         reference_level_ff <= REFERENCE_LEVEL_RESET;
         tracking_range_ff  <= TRACKING_RANGE_RESET;
         hysteresis_band_ff <= HYSTERESIS_BAND_RESET;
         hold_time_ms_ff    <= HOLD_TIME_MS_RESET;
         phon_rate_ff       <= PHON_RATE_RESET;
         bypass_mode_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REFERENCE_LEVEL: reference_level_ff <= csr_data[14:0];
            CSR_TRACKING_RANGE:  tracking_range_ff  <= csr_data[12:0];
            CSR_HYSTERESIS_BAND: hysteresis_band_ff <= csr_data[9:0];
            CSR_HOLD_TIME_MS:    hold_time_ms_ff    <= csr_data[21:0];
            CSR_PHON_RATE:       phon_rate_ff       <= csr_data[15:0];
            CSR_BYPASS_MODE:     bypass_mode_ff     <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en0)    s0_valid_ff  <= req_valid;
         if (en1)    s1_valid_ff  <= s0_valid_ff;
         if (en2)    s2_valid_ff  <= s1_valid_ff;
         if (en3)    s3_valid_ff  <= s2_valid_ff;
         if (en_out) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (en0) begin
         s0_opcode_ff      <= req_opcode;
         s0_level_ff       <= req_level;
         s0_level_valid_ff <= req_level_valid;
         s0_ts_ff          <= req_timestamp_ms;
      end
   end

   // Stage 1: elapsed time, silence time, status and level clamp.
   logic [TIME_BITS-1:0] elapsed_raw, since;
   logic signed [15:0]   ref_ext, floor_raw, floor_lvl, clamp_lvl;

   always_comb begin
      ref_ext   = {reference_level_ff[14], reference_level_ff};
      floor_raw = ref_ext - $signed({3'b000, tracking_range_ff});
      floor_lvl = (floor_raw < LEVEL_MIN) ? LEVEL_MIN : floor_raw;
      clamp_lvl = s0_level_ff;
      if (clamp_lvl < floor_lvl) clamp_lvl = floor_lvl;
      if (clamp_lvl > ref_ext) clamp_lvl = ref_ext;

      if ((advance_time_ff != '0) && (s0_ts_ff > advance_time_ff)) begin
         elapsed_raw = s0_ts_ff - advance_time_ff;
      end else begin
         elapsed_raw = '0;
      end
      if (elapsed_raw > ELAPSED_CAP) begin
         s1_elapsed_in = ELAPSED_CAP[ELAPSED_BITS-1:0];
      end else begin
         s1_elapsed_in = elapsed_raw[ELAPSED_BITS-1:0];
      end

      since = (s0_ts_ff >= measure_time_ff) ? (s0_ts_ff - measure_time_ff) : '0;
   end

   always_comb begin
      s1_ctl_in        = '0;
      s1_ctl_in.status = mode_status_ff;
      s1_ctl_in.level  = clamp_lvl[LEVEL_BITS-1:0];
      mode_status_in   = mode_status_ff;
      seen_in          = seen_ff;
      measure_time_in  = measure_time_ff;
      advance_time_in  = advance_time_ff;
      if (s0_valid_ff) begin
         if (s0_opcode_ff == OP_TICK) begin
            advance_time_in      = s0_ts_ff;
            s1_ctl_in.elapsed_nz = (elapsed_raw != '0);
            if (bypass_mode_ff) begin
               s1_ctl_in.status      = STATUS_BYPASSED;
               s1_ctl_in.pull        = 1'b1;
               s1_ctl_in.tick_active = 1'b1;
            end else if (!seen_ff) begin
               s1_ctl_in.status = STATUS_WAITING;
            end else begin
               s1_ctl_in.tick_active = 1'b1;
               if (since > TIME_BITS'(hold_time_ms_ff)) begin
                  s1_ctl_in.status = STATUS_RELEASING;
                  s1_ctl_in.pull   = 1'b1;
               end else if (since > STALE_LIMIT) begin
                  s1_ctl_in.status = STATUS_STALE;
               end else begin
                  s1_ctl_in.status = STATUS_TRACKING;
               end
            end
            mode_status_in = s1_ctl_in.status;
         end else if (s0_level_valid_ff) begin
            s1_ctl_in.meas_update = 1'b1;
            s1_ctl_in.first       = !seen_ff;
            seen_in               = 1'b1;
            measure_time_in       = s0_ts_ff;
         end
      end
   end

   // Time and status state, updated as an item enters stage 1.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_status_ff  <= STATUS_WAITING;
         seen_ff         <= 1'b0;
         measure_time_ff <= '0;
         advance_time_ff <= '0;
      end else if (en1) begin
         mode_status_ff  <= mode_status_in;
         seen_ff         <= seen_in;
         measure_time_ff <= measure_time_in;
         advance_time_ff <= advance_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ctl_ff     <= s1_ctl_in;
         s1_elapsed_ff <= s1_elapsed_in;
      end
   end

   // Stage 2: rate times elapsed milliseconds.
   always_ff @(posedge clock) begin
      if (en2) begin
         s2_ctl_ff     <= s1_ctl_ff;
         s2_product_ff <= PRODUCT_BITS'(phon_rate_ff) * PRODUCT_BITS'(s1_elapsed_ff);
      end
   end

   // Stage 3: divide by 1000 through the reciprocal and saturate the step.
   logic [QUOT_IN_BITS+RECIP_BITS-1:0] recip_product;

   always_comb begin
      recip_product = (QUOT_IN_BITS + RECIP_BITS)'(s2_product_ff[QUOT_IN_BITS-1:0])
                    * (QUOT_IN_BITS + RECIP_BITS)'(RECIP_1000);
      if (s2_product_ff >= PRODUCT_BITS'(STEP_SAT_PRODUCT)) begin
         s3_step_in = STEP_BITS'(STEP_MAX);
      end else begin
         s3_step_in = recip_product[RECIP_SHIFT+STEP_BITS-1:RECIP_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_ctl_ff  <= s2_ctl_ff;
         s3_step_ff <= s3_step_in;
      end
   end

   // Final stage: hysteresis update of the target and slew of the tracked level.
   logic signed [15:0] lvl_ext, hyst_ext, step_ext, tgt_new;
   logic signed [16:0] diff, err;
   logic [16:0]        abs_diff, abs_err;

   always_comb begin
      lvl_ext    = {s3_ctl_ff.level[LEVEL_BITS-1], s3_ctl_ff.level};
      hyst_ext   = $signed({6'b000000, hysteresis_band_ff});
      step_ext   = $signed({1'b0, s3_step_ff});
      target_in  = target_ff;
      tracked_in = tracked_ff;
      refresh_in = 1'b0;

      diff     = {lvl_ext[15], lvl_ext} - {target_ff[15], target_ff};
      abs_diff = diff[16] ? 17'(-diff) : 17'(diff);

      tgt_new = s3_ctl_ff.pull ? ref_ext : target_ff;
      err     = {tgt_new[15], tgt_new} - {tracked_ff[15], tracked_ff};
      abs_err = err[16] ? 17'(-err) : 17'(err);

      if (s3_valid_ff) begin
         if (s3_ctl_ff.meas_update) begin
            if (s3_ctl_ff.first) begin
               target_in  = lvl_ext;
               tracked_in = ref_ext;
               refresh_in = 1'b1;
            end else if (abs_diff > {7'b0000000, hysteresis_band_ff}) begin
               target_in = (diff > 17'sd0) ? (lvl_ext - hyst_ext) : (lvl_ext + hyst_ext);
            end
         end else if (s3_ctl_ff.tick_active) begin
            target_in = tgt_new;
            if (s3_ctl_ff.elapsed_nz) begin
               refresh_in = 1'b1;
               if (abs_err <= {2'b00, s3_step_ff}) begin
                  tracked_in = tgt_new;
               end else if (err > 17'sd0) begin
                  tracked_in = tracked_ff + step_ext;
               end else begin
                  tracked_in = tracked_ff - step_ext;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= {REFERENCE_LEVEL_RESET[14], REFERENCE_LEVEL_RESET};
         tracked_ff <= {REFERENCE_LEVEL_RESET[14], REFERENCE_LEVEL_RESET};
      end else if (en_out) begin
         target_ff  <= target_in;
         tracked_ff <= tracked_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_status_ff  <= s3_ctl_ff.status;
         rsp_target_ff  <= target_in[LEVEL_BITS-1:0];
         rsp_tracked_ff <= tracked_in[LEVEL_BITS-1:0];
         rsp_refresh_ff <= refresh_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_target_level  = rsp_target_ff;
   assign rsp_tracked_level = rsp_tracked_ff;
   assign rsp_curve_refresh = rsp_refresh_ff;

endmodule

`default_nettype wire

[design/lths_checker.sv]
// Port-level checker of the level tracker and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "level_tracker_hysteresis_slew_core_macros.svh"

module lths_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [lths_pkg::STATUS_BITS-1:0] rsp_status,
   input wire logic signed [lths_pkg::LEVEL_BITS-1:0] rsp_target_level,
   input wire logic signed [lths_pkg::LEVEL_BITS-1:0] rsp_tracked_level,
   input wire logic                             rsp_curve_refresh
);

   import lths_pkg::*;

   // The input side is held back only while a result waits on a stalled receiver.
   `LTHS_ASSERT(a_stall_only_when_full, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "req_stall raised without a stalled result")

   // Reset empties the result register.
   `LTHS_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result holds its payload.
   `LTHS_ASSERT(a_result_holds, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_target_level) && $stable(rsp_tracked_level) && $stable(rsp_curve_refresh)), "stalled result changed")

   // Every result carries one of the defined status codes.
   `LTHS_ASSERT(a_status_known, clock, reset, rsp_valid |-> (rsp_status <= STATUS_TRACKING), "status code out of range")

endmodule

bind level_tracker_hysteresis_slew_core lths_checker u_lths_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the loudness level tracker core.
`timescale 1ns / 1ps

module tb_top;
   import lths_pkg::*;

   // Run shape and limits.
   localparam int SETTING_PHASES  = 11;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int STALL_LIMIT     = 1000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int REPORT_LIMIT    = 10;

   // Tracker constants used by the predictor.
   localparam int          STALE_AFTER_MS = 2000;
   localparam int          SLEW_LIMIT     = 32767;
   localparam int          LEVEL_LOWEST   = -16384;
   localparam logic [63:0] ELAPSED_CLAMP  = 64'd67108864;

   // Register indexes that the block does not decode.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 3'd7;

   // Kinds of register settings loaded between phases.
   localparam int SETTINGS_RANDOM  = 0;
   localparam int SETTINGS_LOWEST  = 1;
   localparam int SETTINGS_HIGHEST = 2;

   // One result transfer as the checker sees it.
   typedef struct packed {
      status_type         status;
      logic signed [14:0] target;
      logic signed [14:0] tracked;
      logic               refresh;
   } level_report_type;

   // One row of the directed stimulus: either an item or a register write.
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [CSR_DATA_BITS-1:0]  data;
      logic                      op;
      logic signed [15:0]        lvl;
      logic                      lvl_ok;
      logic [47:0]               ts;
      logic                      typed;
      level_report_type          want;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 38;

   // Directed rows. Rows marked typed carry the result worked out by hand
   // from reset settings; the rest are checked against the predictor.
   localparam stim_row_type DIRECTED [0:DIRECTED_COUNT-1] = '{
      // First tick and a tick right after it: still waiting, nothing slews.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd0,
        1'b1, '{STATUS_WAITING, 15'sd10880, 15'sd10880, 1'b0}},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd1000,
        1'b1, '{STATUS_WAITING, 15'sd10880, 15'sd10880, 1'b0}},
      // Invalid measurement changes nothing.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, 16'sh8000, 1'b0, 48'd500,
        1'b1, '{STATUS_WAITING, 15'sd10880, 15'sd10880, 1'b0}},
      // First valid measurement, clamped to the reference, sets the target.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, 16'sh7FFF, 1'b1, 48'd1000,
        1'b1, '{STATUS_WAITING, 15'sd10880, 15'sd10880, 1'b1}},
      // Lowest level clamps to the floor and drags the target to the band edge.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, 16'sh8000, 1'b1, 48'd1100,
        1'b1, '{STATUS_WAITING, 15'sd9088, 15'sd10880, 1'b0}},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd2000,
        1'b1, '{STATUS_TRACKING, 15'sd9088, 15'sd10638, 1'b1}},
      // Inside the deadband: target holds.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, 16'sd9000, 1'b1, 48'd2000,
        1'b1, '{STATUS_TRACKING, 15'sd9088, 15'sd10638, 1'b0}},
      // Zero elapsed time: no slew and no refresh.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd2000,
        1'b1, '{STATUS_TRACKING, 15'sd9088, 15'sd10638, 1'b0}},
      // Stale after more than two seconds without a measurement.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd4500,
        1'b1, '{STATUS_STALE, 15'sd9088, 15'sd10033, 1'b1}},
      // Time going backward.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd3000,
        1'b1, '{STATUS_TRACKING, 15'sd9088, 15'sd10033, 1'b0}},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, 16'sd9500, 1'b1, 48'd50000,
        1'b1, '{STATUS_TRACKING, 15'sd9372, 15'sd10033, 1'b0}},
      // Measurement later than the tick still counts as tracking.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd40000,
        1'b1, '{STATUS_TRACKING, 15'sd9372, 15'sd9372, 1'b1}},
      // Hold time expired: release to the reference.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd90000,
        1'b1, '{STATUS_RELEASING, 15'sd10880, 15'sd10880, 1'b1}},
      // Largest timestamp: elapsed time and step both saturate.
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b1, 48'hFFFF_FFFF_FFFF,
        1'b1, '{STATUS_RELEASING, 15'sd10880, 15'sd10880, 1'b1}},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, 16'sd0, 1'b1, 48'hFFFF_FFFF_FFFF,
        1'b1, '{STATUS_RELEASING, 15'sd9088, 15'sd10880, 1'b0}},
      // Bypass forces the status and pulls the target back.
      '{ROW_CSR, CSR_BYPASS_MODE, 22'd1, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd100,
        1'b0, '0},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, 16'sd10000, 1'b1, 48'd150,
        1'b0, '0},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd250,
        1'b0, '0},
      // Lowest reference with the widest range: floor saturates.
      '{ROW_CSR, CSR_BYPASS_MODE, 22'd0, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_CSR, CSR_REFERENCE_LEVEL, 22'h004000, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_CSR, CSR_TRACKING_RANGE, 22'd8191, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_CSR, CSR_HYSTERESIS_BAND, 22'd1023, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_CSR, CSR_HOLD_TIME_MS, 22'd0, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_CSR, CSR_PHON_RATE, 22'd65535, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, 16'sh8000, 1'b1, 48'd300,
        1'b0, '0},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd301,
        1'b0, '0},
      // Highest reference, no range and no deadband.
      '{ROW_CSR, CSR_REFERENCE_LEVEL, 22'h003FFF, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_CSR, CSR_TRACKING_RANGE, 22'd0, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_CSR, CSR_HYSTERESIS_BAND, 22'd0, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, 16'sh7FFF, 1'b1, 48'd400,
        1'b0, '0},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_MEASURE, -16'sd5, 1'b1, 48'd400,
        1'b0, '0},
      // One-hour hold and a zero rate: refresh without movement.
      '{ROW_CSR, CSR_HOLD_TIME_MS, 22'd3600000, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_CSR, CSR_PHON_RATE, 22'd0, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd401,
        1'b0, '0},
      // Writes to undecoded indexes must leave every setting alone.
      '{ROW_CSR, CSR_SPARE_LOW, 22'h3FFFFF, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_CSR, CSR_SPARE_HIGH, 22'h3FFFFF, OP_MEASURE, 16'sd0, 1'b0, 48'd0,
        1'b0, '0},
      '{ROW_ITEM, CSR_REFERENCE_LEVEL, 22'd0, OP_TICK, 16'sd0, 1'b0, 48'd402,
        1'b0, '0}
   };

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Block ports.
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_opcode = OP_MEASURE;
   logic signed [15:0]        req_level = '0;
   logic                      req_level_valid = 1'b0;
   logic [47:0]               req_timestamp_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic signed [14:0]        rsp_target_level;
   logic signed [14:0]        rsp_tracked_level;
   logic                      rsp_curve_refresh;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // Predictor copy of the settings.
   logic signed [14:0] cfg_reference = REFERENCE_LEVEL_RESET;
   logic [12:0]        cfg_range     = TRACKING_RANGE_RESET;
   logic [9:0]         cfg_band      = HYSTERESIS_BAND_RESET;
   logic [21:0]        cfg_hold      = HOLD_TIME_MS_RESET;
   logic [15:0]        cfg_rate      = PHON_RATE_RESET;
   logic               cfg_bypass    = 1'b0;

   // Predictor copy of the tracker state.
   status_type         trk_mode    = STATUS_WAITING;
   logic signed [14:0] trk_target  = REFERENCE_LEVEL_RESET;
   logic signed [14:0] trk_tracked = REFERENCE_LEVEL_RESET;
   logic               trk_seen    = 1'b0;
   logic [47:0]        trk_meas_ms = '0;
   logic [47:0]        trk_tick_ms = '0;

   // Results still owed by the block, oldest first.
   level_report_type pending_reports[$];

   // Run bookkeeping.
   int          mismatch_count = 0;
   int          items_sent     = 0;
   int          results_seen   = 0;
   int          csr_writes     = 0;
   int          idle_cycles    = 0;
   logic        send_idle_on   = 1'b1;
   logic        sink_idle_on   = 1'b1;
   logic [47:0] now_ms         = 48'd1000;

   level_tracker_hysteresis_slew_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_level         (req_level),
      .req_level_valid   (req_level_valid),
      .req_timestamp_ms  (req_timestamp_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_target_level  (rsp_target_level),
      .rsp_tracked_level (rsp_tracked_level),
      .rsp_curve_refresh (rsp_curve_refresh),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one item to the predicted tracker state and return its result.
   function automatic level_report_type tracker_update(input logic op,
         input logic signed [15:0] lvl, input logic lvl_ok, input logic [47:0] ts);
      level_report_type rep;
      int               floor_lvl;
      int               clamped;
      int               diff;
      int               step_sz;
      int               err;
      logic [63:0]      elapsed;
      logic [63:0]      since_meas;
      logic [63:0]      rate_wide;
      logic [63:0]      slew;
      rep.refresh = 1'b0;
      if (op == OP_MEASURE) begin
         if (lvl_ok) begin
            // Clamp into [reference - range, reference], floor saturating.
            floor_lvl = int'(cfg_reference) - int'(cfg_range);
            if (floor_lvl < LEVEL_LOWEST) floor_lvl = LEVEL_LOWEST;
            clamped = int'(lvl);
            if (clamped < floor_lvl) clamped = floor_lvl;
            if (clamped > int'(cfg_reference)) clamped = int'(cfg_reference);
            trk_meas_ms = ts;
            if (!trk_seen) begin
               trk_target  = 15'(clamped);
               trk_tracked = cfg_reference;
               trk_seen    = 1'b1;
               rep.refresh = 1'b1;
            end else begin
               // Leaving the deadband moves the target to the band edge.
               diff = clamped - int'(trk_target);
               if ((diff < 0 ? -diff : diff) > int'(cfg_band)) begin
                  trk_target = 15'((diff > 0) ? clamped - int'(cfg_band)
                                              : clamped + int'(cfg_band));
               end
            end
         end
      end else begin
         // A stored tick time of zero means no tick has been seen yet.
         elapsed = '0;
         if (trk_tick_ms != '0 && ts > trk_tick_ms) elapsed = ts - trk_tick_ms;
         trk_tick_ms = ts;
         if (cfg_bypass) begin
            trk_mode   = STATUS_BYPASSED;
            trk_target = cfg_reference;
         end else if (!trk_seen) begin
            trk_mode = STATUS_WAITING;
         end else begin
            since_meas = (ts >= trk_meas_ms) ? ts - trk_meas_ms : '0;
            if (since_meas > cfg_hold) begin
               trk_mode   = STATUS_RELEASING;
               trk_target = cfg_reference;
            end else if (since_meas > STALE_AFTER_MS) begin
               trk_mode = STATUS_STALE;
            end else begin
               trk_mode = STATUS_TRACKING;
            end
         end
         // Slew toward the target unless still waiting or no time passed.
         if (elapsed != '0 && (cfg_bypass || trk_seen)) begin
            if (elapsed > ELAPSED_CLAMP) elapsed = ELAPSED_CLAMP;
            rate_wide = cfg_rate;
            slew      = (rate_wide * elapsed) / 64'd1000;
            step_sz   = (slew > SLEW_LIMIT) ? SLEW_LIMIT : int'(slew);
            err       = int'(trk_target) - int'(trk_tracked);
            if ((err < 0 ? -err : err) <= step_sz) trk_tracked = trk_target;
            else trk_tracked = 15'((err > 0) ? int'(trk_tracked) + step_sz
                                             : int'(trk_tracked) - step_sz);
            rep.refresh = 1'b1;
         end
      end
      rep.status  = trk_mode;
      rep.target  = trk_target;
      rep.tracked = trk_tracked;
      return rep;
   endfunction

   // Offer one item after a random gap, if the sender idles, and log its expected result on transfer.
   task automatic send_item(input logic op, input logic signed [15:0] lvl,
         input logic lvl_ok, input logic [47:0] ts, input logic typed,
         input level_report_type want);
      int               gap;
      level_report_type predicted;
      gap = send_idle_on ? $urandom_range(0, 9) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_level        <= lvl;
      req_level_valid  <= lvl_ok;
      req_timestamp_ms <= ts;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = tracker_update(op, lvl, lvl_ok, ts);
      pending_reports.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Hold off the sender until every expected result has arrived.
   task automatic pause_until_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // Write one register and mirror it in the predictor settings.
   task automatic write_setting(input logic [CSR_INDEX_BITS-1:0] idx,
         input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_REFERENCE_LEVEL: cfg_reference = data[14:0];
         CSR_TRACKING_RANGE:  cfg_range     = data[12:0];
         CSR_HYSTERESIS_BAND: cfg_band      = data[9:0];
         CSR_HOLD_TIME_MS:    cfg_hold      = data[21:0];
         CSR_PHON_RATE:       cfg_rate      = data[15:0];
         CSR_BYPASS_MODE:     cfg_bypass    = data[0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Load a full set of registers: random, all lowest, or all highest but a one-hour hold.
   task automatic load_settings(input int style);
      logic signed [14:0] ref_v;
      logic [12:0]        range_v;
      logic [9:0]         band_v;
      logic [21:0]        hold_v;
      logic [15:0]        rate_v;
      logic               bypass_v;
      if (style == SETTINGS_LOWEST) begin
         ref_v = 15'sh4000;
         range_v = '0;
         band_v = '0;
         hold_v = '0;
         rate_v = '0;
         bypass_v = 1'b0;
      end else if (style == SETTINGS_HIGHEST) begin
         ref_v = 15'sh3FFF;
         range_v = 13'd8191;
         band_v = 10'd1023;
         hold_v = 22'd3600000;
         rate_v = 16'hFFFF;
         bypass_v = 1'b1;
      end else begin
         // Mostly near the usual operating point, sometimes anywhere.
         if ($urandom_range(0, 3) != 0) ref_v = 15'(10880 - 2000 + $urandom_range(0, 4000));
         else ref_v = 15'($urandom_range(0, 32767));
         range_v = 13'($urandom_range(0, 8191));
         band_v  = 10'($urandom_range(0, 1023));
         case ($urandom_range(0, 3))
            0: hold_v = 22'($urandom_range(0, 5000));
            1: hold_v = 22'($urandom_range(5000, 40000));
            2: hold_v = 22'($urandom_range(0, 3600000));
            default: hold_v = 22'($urandom_range(0, 22'h3FFFFF));
         endcase
         rate_v   = 16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 2000) : $urandom);
         bypass_v = ($urandom_range(0, 4) == 0);
      end
      write_setting(CSR_REFERENCE_LEVEL, {7'd0, ref_v});
      write_setting(CSR_TRACKING_RANGE, {9'd0, range_v});
      write_setting(CSR_HYSTERESIS_BAND, {12'd0, band_v});
      write_setting(CSR_HOLD_TIME_MS, hold_v);
      write_setting(CSR_PHON_RATE, {6'd0, rate_v});
      write_setting(CSR_BYPASS_MODE, {21'd0, bypass_v});
   endtask

   // One random item on a mostly forward-moving clock of milliseconds.
   task automatic send_random_item;
      logic               op;
      logic               lvl_ok;
      logic signed [15:0] lvl;
      int                 lvl_i;
      int                 jump;
      jump = $urandom_range(0, 99);
      if (jump < 70) now_ms = now_ms + $urandom_range(0, 1500);
      else if (jump < 85) now_ms = now_ms + $urandom_range(1500, 40000);
      else if (jump < 92) now_ms = now_ms - $urandom_range(0, 3000);
      else if (jump < 97) now_ms = now_ms + $urandom_range(0, 4000000);
      else now_ms = 48'({$urandom, $urandom});
      op     = ($urandom_range(0, 9) < 4) ? OP_TICK : OP_MEASURE;
      lvl_ok = ($urandom_range(0, 9) != 0);
      // Levels mostly around the tracking window so the deadband is exercised.
      if ($urandom_range(0, 4) != 0) begin
         lvl_i = int'(cfg_reference) - int'(cfg_range) - 300
               + int'($urandom_range(0, int'(cfg_range) + 600));
         lvl = lvl_i[15:0];
      end else begin
         lvl = 16'($urandom);
      end
      send_item(op, lvl, lvl_ok, now_ms, 1'b0, '0);
   endtask

   // Result side: random stall before each transfer, or none in steady phases.
   initial begin : result_sink
      int hold_cycles;
      forever begin
         hold_cycles = sink_idle_on ? $urandom_range(0, 9) : 0;
         repeat (hold_cycles) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   // Compare every result transfer with the oldest expectation.
   always @(posedge clock) begin : check_results
      level_report_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: result transfer with none expected: status %0d target %0d",
                        $realtime, rsp_status, rsp_target_level);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_status !== want.status || rsp_target_level !== want.target ||
                rsp_tracked_level !== want.tracked ||
                rsp_curve_refresh !== want.refresh) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: result %0d expected status %0d target %0d tracked %0d %s",
                           $realtime, results_seen, want.status, want.target,
                           want.tracked, want.refresh ? "refresh 1" : "refresh 0");
                  $display("   got status %0d target %0d tracked %0d refresh %0d",
                           rsp_status, rsp_target_level, rsp_tracked_level,
                           rsp_curve_refresh);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which no channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $realtime, STALL_LIMIT, pending_reports.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Main sequence: reset, directed rows, then random phases of settings.
   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            pause_until_drained();
            write_setting(DIRECTED[i].idx, DIRECTED[i].data);
         end else begin
            send_item(DIRECTED[i].op, DIRECTED[i].lvl, DIRECTED[i].lvl_ok, DIRECTED[i].ts,
                      DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      for (int phase = 0; phase < SETTING_PHASES; phase++) begin
         pause_until_drained();
         if (phase == 2) load_settings(SETTINGS_LOWEST);
         else if (phase == 6) load_settings(SETTINGS_HIGHEST);
         else load_settings(SETTINGS_RANDOM);
         // Every fourth phase runs with neither side idling.
         send_idle_on = (phase % 4 != 3) && ($urandom_range(0, 3) != 0);
         sink_idle_on = (phase % 4 != 3) && ($urandom_range(0, 3) != 0);
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 3) pause_until_drained();
            send_random_item();
         end
      end

      // Let the pipeline empty, then watch for stray results.
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d items (%0d directed rows) and %0d register writes.",
               items_sent, DIRECTED_COUNT, csr_writes);
      $display("Checked %0d result transfers over %0d setting phases, %0d miscompares.",
               results_seen, SETTING_PHASES, mismatch_count);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/lths_pkg.sv
design/level_tracker_hysteresis_slew_core.sv
design/lths_checker.sv
sim/tb_top.sv
